>>> design/s64a_pkg.sv
// ----------------------------------------------------------------------------
// s64a_pkg
// shared types, constants and helpers for the signed int64 to ascii core
// ----------------------------------------------------------------------------
package s64a_pkg;

    localparam int VALUE_W   = 64;
    localparam int DIGITS    = 19;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int CHAR_W    = 6;
    localparam int STEP_W    = $clog2(VALUE_W);
    localparam int LEFT_W    = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    typedef enum logic [1:0] {
        DAB_IDLE,
        DAB_RUN,
        DAB_DONE
    } dab_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_SKIP,
        EM_DIGIT
    } emit_state_t;

    typedef struct packed {
        logic             negative;
        logic [BCD_W-1:0] bcd;
    } dab_result_t;

    function automatic logic bcd_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd[i*4 +: 4] > 4'd9)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

>>> design/signed_int64_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// signed_int64_to_decimal_ascii_core
// signed 64-bit integer to decimal ascii text, one character per transfer
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one transfer carries a signed 64-bit value in s_tdata
//   m_* channel: one transfer per character, most significant first; a
//   negative value starts with '-', leading zeros are dropped, zero gives
//   '0'; m_tlast marks the final character (1 to 20 characters per value)
// operation
//   the converter loads the magnitude and shifts it into bcd one bit per
//   cycle and hands the result off; the character stage sends the sign,
//   steps over each leading zero (up to 18), leaves the skip and then
//   sends one character per digit
//   conversion of the next value overlaps the output of the current one
// reset and stalls
//   rst_n clears all control state; no transfer is pending after reset
//   m_tready low holds the current character in the output register and
//   stalls sign and digits; s_tready drops once the converter is full
// ----------------------------------------------------------------------------
module signed_int64_to_decimal_ascii_core
    import s64a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[5:0], zero[7:6]
    output logic        m_tlast
);

    logic              dab_valid;
    logic              dab_ready;
    dab_result_t       dab_result;
    logic [CHAR_W-1:0] out_char;

    s64a_dabble u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_value   (s_tdata),
        .out_valid  (dab_valid),
        .out_ready  (dab_ready),
        .out_result (dab_result)
    );

    s64a_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dab_valid),
        .in_ready  (dab_ready),
        .in_result (dab_result),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_char    (out_char),
        .m_last    (m_tlast)
    );

    assign m_tdata = {2'b00, out_char};

endmodule

>>> design/s64a_dabble.sv
// ----------------------------------------------------------------------------
// s64a_dabble
// bit-serial shift-and-add-3 conversion of a magnitude to packed bcd
// ----------------------------------------------------------------------------
module s64a_dabble
    import s64a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output dab_result_t        out_result
);

    dab_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic              neg_reg, neg_next;
    logic [BCD_W-1:0]  adj;

    // add 3 to every digit of five or more before the shift
    always_comb
    begin
        logic [3:0] d;
        d = 4'd0;
        for (int i = 0; i < DIGITS; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            adj[i*4 +: 4] = (d >= 4'd5) ? 4'(d + 4'd3) : d;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DAB_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = DAB_RUN;
                end
            end
            DAB_RUN:
            begin
                if (step_reg == '0)
                begin
                    state_next = DAB_DONE;
                end
            end
            DAB_DONE:
            begin
                if (out_ready)
                begin
                    state_next = DAB_IDLE;
                end
            end
            default:
            begin
                state_next = DAB_IDLE;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        neg_next  = neg_reg;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            DAB_IDLE:
            begin
                in_ready  = 1'b1;
                neg_next  = in_value[VALUE_W-1];
                bin_next  = in_value[VALUE_W-1] ? VALUE_W'(~in_value + 1'b1) : in_value;
                bcd_next  = '0;
                step_next = STEP_W'(VALUE_W - 1);
            end
            DAB_RUN:
            begin
                bcd_next  = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next  = {bin_reg[VALUE_W-2:0], 1'b0};
                step_next = step_reg - 1'b1;
            end
            DAB_DONE:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                out_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DAB_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
    end

    assign out_result.negative = neg_reg;
    assign out_result.bcd      = bcd_reg;

`ifndef SYNTHESIS
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DAB_RUN && step_reg == '0) |=> state_reg == DAB_DONE)
        else $error("conversion did not finish after the last shift");

    a_bcd_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DAB_DONE) |-> bcd_ok(bcd_reg))
        else $error("bcd result holds a digit above nine");
`endif

endmodule

>>> design/s64a_emit.sv
// ----------------------------------------------------------------------------
// s64a_emit
// walks the bcd digits from the top, drops leading zeros and sends characters
// ----------------------------------------------------------------------------
module s64a_emit
    import s64a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dab_result_t       in_result,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_char,
    output logic              m_last
);

    emit_state_t       state_reg, state_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              oval_reg, oval_next;
    logic [CHAR_W-1:0] ochar_reg, ochar_next;
    logic              olast_reg, olast_next;

    logic              slot_free;
    logic [3:0]        top_digit;
    logic              emit_en;
    logic [CHAR_W-1:0] emit_char;
    logic              emit_last;

    assign slot_free = !oval_reg || m_ready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_result.negative ? EM_SIGN : EM_SKIP;
                end
            end
            EM_SIGN:
            begin
                if (slot_free)
                begin
                    state_next = EM_SKIP;
                end
            end
            EM_SKIP:
            begin
                if (top_digit != 4'd0 || left_reg == LEFT_W'(1))
                begin
                    state_next = EM_DIGIT;
                end
            end
            EM_DIGIT:
            begin
                if (slot_free && left_reg == LEFT_W'(1))
                begin
                    state_next = EM_IDLE;
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bcd_next  = bcd_reg;
        left_next = left_reg;
        in_ready  = 1'b0;
        emit_en   = 1'b0;
        emit_char = CHAR_ZERO;
        emit_last = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                in_ready  = 1'b1;
                bcd_next  = in_result.bcd;
                left_next = LEFT_W'(DIGITS);
            end
            EM_SIGN:
            begin
                emit_en   = slot_free;
                emit_char = CHAR_MINUS;
            end
            EM_SKIP:
            begin
                if (top_digit == 4'd0 && left_reg != LEFT_W'(1))
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next = left_reg - 1'b1;
                end
            end
            EM_DIGIT:
            begin
                emit_en   = slot_free;
                emit_char = CHAR_W'(CHAR_ZERO + {2'b00, top_digit});
                emit_last = (left_reg == LEFT_W'(1));
                if (slot_free)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next = left_reg - 1'b1;
                end
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    // output register
    always_comb
    begin
        oval_next  = oval_reg;
        ochar_next = ochar_reg;
        olast_next = olast_reg;
        if (emit_en)
        begin
            oval_next  = 1'b1;
            ochar_next = emit_char;
            olast_next = emit_last;
        end
        else if (m_ready)
        begin
            oval_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EM_IDLE;
            oval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oval_reg  <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg   <= bcd_next;
        left_reg  <= left_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign m_valid = oval_reg;
    assign m_char  = ochar_reg;
    assign m_last  = olast_reg;

`ifndef SYNTHESIS
    a_digit_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EM_DIGIT) |-> left_reg != '0)
        else $error("digit phase with no digits left");

    a_skip_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EM_SKIP && left_reg == LEFT_W'(1)) |=> state_reg == EM_DIGIT)
        else $error("zero skip ran past the units digit");
`endif

endmodule

>>> bench/s64a_checker.sv
// ----------------------------------------------------------------------------
// s64a_checker
// watches both stream channels of the int64 to ascii core, predicts the
// decimal text of every accepted value and compares it, character by
// character, with the characters the core sends out
// ----------------------------------------------------------------------------
module s64a_checker
    import s64a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // character[5:0], zero[7:6]
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t text_chars[$];
    text_char_t want;

    function automatic void push_decimal_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits[$];
        text_char_t         c;
        magnitude = value[VALUE_W-1] ? (~value + 1'b1) : value;
        do
        begin
            digits.push_front(4'(magnitude % 10));
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        if (value[VALUE_W-1])
        begin
            c.code = CHAR_MINUS;
            c.last = 1'b0;
            text_chars.push_back(c);
        end
        foreach (digits[i])
        begin
            c.code = CHAR_ZERO + CHAR_W'(digits[i]);
            c.last = 1'b0;
            text_chars.push_back(c);
        end
        text_chars[text_chars.size()-1].last = 1'b1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                push_decimal_text(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (text_chars.size() == 0)
                begin
                    $display("%0t: unexpected character: expected none, actual %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = text_chars.pop_front();
                    if (m_tdata !== {2'b00, want.code} || m_tlast !== want.last)
                    begin
                        $display("%0t: mismatch: expected %h last %b, actual %h last %b",
                                 $time, {2'b00, want.code}, want.last, m_tdata, m_tlast);
                        mismatches++;
                    end
                end
            end
            pending = text_chars.size();
        end
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// drives signed 64-bit values into the int64 to ascii core: corner values
// first, then random values of every length and sign, with random idle
// bursts on both channels and one long output hold-off; the checker
// predicts and compares the text
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM   = 258;
    localparam int QUIET_FROM = 210;
    localparam int HOLD_AT    = 40;
    localparam int HOLD_LEN   = 600;
    localparam int WATCHDOG   = 3000;
    localparam int DRAIN      = 100;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // value[63:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // character[5:0], zero[7:6]
    logic        m_tlast;

    int   mismatches;
    int   pending;
    int   n_sent;
    int   stuck_cycles;
    logic quiet;
    logic held_off;

    logic [63:0] corner_values[$] = '{
        64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99, 64'd100,
        64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001,
        64'd1000000000000000000, -64'sd1000000000000000000,
        64'd999999999999999999, -64'sd999999999999999999,
        64'd1000000000, -64'sd123456789, 64'd12345,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA
    };

    signed_int64_to_decimal_ascii_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    s64a_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] pick_value();
        int          mode;
        int          n_digits;
        logic [63:0] p10;
        logic [63:0] v;
        mode = $urandom_range(0, 9);
        p10  = 64'd1;
        if (mode < 4)
        begin
            v = {$urandom, $urandom};
        end
        else if (mode < 8)
        begin
            // random length, 1 to 19 digits
            n_digits = $urandom_range(1, 19);
            repeat (n_digits) p10 = p10 * 10;
            v = {$urandom, $urandom} % p10;
            if ($urandom_range(0, 1))
            begin
                v = -v;
            end
        end
        else
        begin
            // around a power of ten
            n_digits = $urandom_range(0, 18);
            repeat (n_digits) p10 = p10 * 10;
            v = p10 + 64'($urandom_range(0, 2)) - 64'd1;
            if ($urandom_range(0, 1))
            begin
                v = -v;
            end
        end
        return v;
    endfunction

    task automatic send_value(input logic [63:0] v);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do
            @(posedge clk);
        while (!s_tready);
        n_sent++;
        @(negedge clk);
    endtask

    // output side: random stalls, one long hold-off, none near the end
    initial
    begin
        int gap;
        m_tready = 1'b0;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && n_sent >= HOLD_AT)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 13);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stuck_cycles = 0;
            end
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= WATCHDOG)
                begin
                    $display("** signed_int64_to_decimal_ascii_core: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        quiet        = 1'b0;
        n_sent       = 0;
        stuck_cycles = 0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (corner_values[i])
        begin
            send_value(corner_values[i]);
        end
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == QUIET_FROM)
            begin
                quiet = 1'b1;
            end
            send_value(pick_value());
        end
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("** signed_int64_to_decimal_ascii_core: PASSED **");
        end
        else
        begin
            $display("** signed_int64_to_decimal_ascii_core: FAILED **");
        end
        $finish;
    end

endmodule
